[hdl/decimal_text_to_integer_saturating_macros.svh]
// Assertion helpers used by the converter RTL.
`ifndef DECIMAL_TEXT_TO_INTEGER_SATURATING_MACROS_SVH
`define DECIMAL_TEXT_TO_INTEGER_SATURATING_MACROS_SVH

// Overlapping implication, checked outside reset.
`define DTIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dtis_pkg.sv]
package dtis_pkg;

    localparam int MAX_TEXT_LEN_DEF = 255;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [1:0]  status;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_SPACES = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } t_phase;

    // result kinds; code 3 behaves as unsigned 64
    localparam logic [1:0] KIND_S32 = 2'd0;
    localparam logic [1:0] KIND_S64 = 2'd1;
    localparam logic [1:0] KIND_U64 = 2'd2;
    localparam logic [1:0] KIND_RESET = KIND_S64;

    // register word index
    localparam logic REG_RESULT_KIND = 1'b0;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [63:0] LIM_S32 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_U64 = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [63:0] Q_S32 = LIM_S32 / 64'd10;
    localparam logic [3:0]  R_S32 = 4'(LIM_S32 % 64'd10);
    localparam logic [63:0] Q_S64 = LIM_S64 / 64'd10;
    localparam logic [3:0]  R_S64 = 4'(LIM_S64 % 64'd10);
    localparam logic [63:0] Q_U64 = LIM_U64 / 64'd10;
    localparam logic [3:0]  R_U64 = 4'(LIM_U64 % 64'd10);

    localparam logic [63:0] MIN_S32 = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;

    // end-of-string record handed to the output stage
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        logic        inv;
        logic        ovf;
        logic [1:0]  kind;
    } t_done;

endpackage

[hdl/decimal_text_to_integer_saturating.sv]
// Channel   | Valid        | Ready        | Payload               | Moves
// ----------+--------------+--------------+-----------------------+---------------------
// text in   | i_in_valid   | o_in_ready   | i_in_data (t_in_item) | one char per request
// result    | o_out_valid  | i_out_ready  | o_out_data(t_out_item)| one per final char
// config    | psel/penable | pready (=1)  | paddr/pwdata/prdata   | APB write/read
//
// One character accepted per cycle while o_in_ready is high; the final character passes through
// r_in and the end record r_d before o_out_valid rises with r_out, where the result can be taken.
// Three registers lie on that path: input, parse state with end record, output.
// The accumulator update (x10 by shift-and-add plus limit compare) is combinational.
// Synchronous active-low reset clears the parser, valids and result_kind (signed 64).
// A stalled output backs up stage by stage; input stalls only when all stages are full.
`include "decimal_text_to_integer_saturating_macros.svh"

module decimal_text_to_integer_saturating #(
    parameter int MAX_TEXT_LEN = dtis_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dtis_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dtis_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CNT_W = $clog2(MAX_TEXT_LEN + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT_LEN);

    logic [1:0] r_kind;

    // stage registers
    logic                r_in_v;
    dtis_pkg::t_in_item  r_in;
    logic                r_d_v;
    dtis_pkg::t_done     r_d;
    logic                r_o_v;
    dtis_pkg::t_out_item r_out;

    // parse state
    logic [63:0]      r_acc, n_acc;
    dtis_pkg::t_phase r_phase, n_phase;
    logic             r_neg, n_neg;
    logic             r_inv, n_inv;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    dtis_pkg::t_done  n_d;

    logic s0_ok, s1_ok, s2_ok, adv_in;

    assign s2_ok  = !r_o_v || i_out_ready;
    assign s1_ok  = !r_d_v || s2_ok;
    assign s0_ok  = !r_in_v || s1_ok;
    assign adv_in = r_in_v && s1_ok;

    assign o_in_ready  = s0_ok;
    assign o_out_valid = r_o_v;
    assign o_out_data  = r_out;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == dtis_pkg::REG_RESULT_KIND) ? {30'd0, r_kind} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= dtis_pkg::KIND_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == dtis_pkg::REG_RESULT_KIND) begin
            r_kind <= pwdata[1:0];
        end
    end

    // ---------------- parser ----------------
    logic [7:0]  c;
    logic        is_digit, is_sign, take, hit;
    logic [3:0]  dig, lim_r;
    logic [63:0] lim_q, acc_x10;
    logic [CNT_W-1:0] cnt_inc;

    assign c        = r_in.text_byte;
    assign is_digit = (c >= dtis_pkg::CH_ZERO) && (c <= dtis_pkg::CH_NINE);
    assign is_sign  = (c == dtis_pkg::CH_PLUS) || (c == dtis_pkg::CH_MINUS);
    assign dig      = c[3:0];
    assign acc_x10  = {r_acc[60:0], 3'b000} + {r_acc[62:0], 1'b0} + {60'd0, dig};
    assign cnt_inc  = (r_cnt <= CNT_MAX) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        case (r_kind)
            dtis_pkg::KIND_S32: begin
                lim_q = dtis_pkg::Q_S32;
                lim_r = dtis_pkg::R_S32;
            end
            dtis_pkg::KIND_S64: begin
                lim_q = dtis_pkg::Q_S64;
                lim_r = dtis_pkg::R_S64;
            end
            default: begin
                lim_q = dtis_pkg::Q_U64;
                lim_r = dtis_pkg::R_U64;
            end
        endcase
    end

    assign hit = (r_acc > lim_q) || ((r_acc == lim_q) && (dig > lim_r));

    always_comb begin
        n_acc   = r_acc;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_inv   = r_inv;
        n_ovf   = r_ovf;
        n_cnt   = r_cnt;
        take    = 1'b0;
        n_d     = '0;
        if (adv_in) begin
            n_cnt = cnt_inc;
            if (cnt_inc > CNT_MAX) begin
                n_inv = 1'b1;
            end
            if (r_phase == dtis_pkg::PH_SPACES) begin
                if (c == dtis_pkg::CH_SPACE) begin
                    n_phase = dtis_pkg::PH_SPACES;
                end else if (is_sign) begin
                    if (r_in.is_final) begin
                        n_inv = 1'b1;
                    end
                    n_neg   = (c == dtis_pkg::CH_MINUS);
                    n_phase = dtis_pkg::PH_SIGN;
                end else if (is_digit) begin
                    take    = 1'b1;
                    n_phase = dtis_pkg::PH_DIGITS;
                end else begin
                    n_inv   = 1'b1;
                    n_phase = dtis_pkg::PH_DIGITS;
                end
            end else begin
                if (is_digit) begin
                    take = 1'b1;
                end else begin
                    n_inv = 1'b1;
                end
                n_phase = dtis_pkg::PH_DIGITS;
            end
            if (take && !r_ovf) begin
                if (hit) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = acc_x10;
                end
            end
            if (r_in.is_final) begin
                n_d.mag  = n_acc;
                n_d.neg  = n_neg;
                n_d.inv  = n_inv;
                n_d.ovf  = n_ovf;
                n_d.kind = r_kind;
                n_acc   = '0;
                n_phase = dtis_pkg::PH_SPACES;
                n_neg   = 1'b0;
                n_inv   = 1'b0;
                n_ovf   = 1'b0;
                n_cnt   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_d_v   <= 1'b0;
            r_o_v   <= 1'b0;
            r_acc   <= '0;
            r_phase <= dtis_pkg::PH_SPACES;
            r_neg   <= 1'b0;
            r_inv   <= 1'b0;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (s0_ok) begin
                r_in_v <= i_in_valid;
            end
            if (s1_ok) begin
                r_d_v <= adv_in && r_in.is_final;
            end
            if (s2_ok) begin
                r_o_v <= r_d_v;
            end
            r_acc   <= n_acc;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_inv   <= n_inv;
            r_ovf   <= n_ovf;
            r_cnt   <= n_cnt;
        end
    end

    // ---------------- result formatting ----------------
    dtis_pkg::t_out_item n_out;

    always_comb begin
        if (r_d.inv) begin
            n_out.value_bits = '0;
            n_out.status     = dtis_pkg::ST_INVALID;
        end else if (r_d.ovf) begin
            n_out.status = dtis_pkg::ST_SATURATED;
            if (r_d.kind[1]) begin
                n_out.value_bits = dtis_pkg::LIM_U64;
            end else if (r_d.kind == dtis_pkg::KIND_S32) begin
                n_out.value_bits = r_d.neg ? dtis_pkg::MIN_S32 : dtis_pkg::LIM_S32;
            end else begin
                n_out.value_bits = r_d.neg ? dtis_pkg::MIN_S64 : dtis_pkg::LIM_S64;
            end
        end else begin
            n_out.status     = dtis_pkg::ST_OK;
            n_out.value_bits = (!r_d.kind[1] && r_d.neg) ? (64'd0 - r_d.mag) : r_d.mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ok) begin
            r_in <= i_in_data;
        end
        if (s1_ok) begin
            r_d <= n_d;
        end
        if (s2_ok) begin
            r_out <= n_out;
        end
    end

    // ---------------- checks ----------------
    `DTIS_ASSERT_NOW(a_spaces_clean, r_phase == dtis_pkg::PH_SPACES, (r_acc == 64'd0) && !r_neg && !r_ovf, "leading-space phase holds stale digits or sign")
    `DTIS_ASSERT_NEXT(a_final_to_record, adv_in && r_in.is_final, r_d_v, "final character produced no end record")
    `DTIS_ASSERT_NOW(a_invalid_zero, o_out_valid && o_out_data.status == dtis_pkg::ST_INVALID, o_out_data.value_bits == 64'd0, "invalid result with nonzero value")
    `DTIS_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_MAX + 1'b1, "length count ran past its limit")

endmodule
